>>> design/md5_pkg.sv
`default_nettype none
package md5_pkg;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;

    // Byte-granular word from the front end to the compression engine
    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_END  = 2'd1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_GATHER,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_EMIT
    } t_state;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] idx);
        logic [4:0] s;
        begin
            unique case (idx)
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/md5_if.sv
`default_nettype none
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface md5_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       digest_last;
    modport source (output valid, digest_byte, digest_last, input ready);
    modport sink   (input valid, digest_byte, digest_last, output ready);
endinterface
`default_nettype wire

>>> design/md5_front.sv
`default_nettype none
// Classifies input items into data and end commands, which enter a small queue
module md5_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    md5_in_if.sink            in_ch,
    output md5_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  wire               i_cmd_pop
);
    import md5_pkg::*;

    localparam int Depth = 4;

    t_cmd       r_q [Depth];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] need;
    logic       fits, take, pop;

    // an item may carry a byte and an end mark: two entries
    assign need        = {1'b0, in_ch.byte_present} + {1'b0, in_ch.end_of_message};
    assign fits        = ({1'b0, r_cnt} + 4'd2) <= 4'(Depth);
    assign in_ch.ready = fits;
    assign take        = in_ch.valid & fits;
    assign o_cmd_valid = r_cnt != 3'd0;
    assign o_cmd       = r_q[r_rp];
    assign pop         = i_cmd_pop & o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (take && in_ch.byte_present) begin
            r_q[r_wp] <= '{op: OP_DATA, data: in_ch.data_byte};
        end
        if (take && in_ch.end_of_message) begin
            r_q[r_wp + {1'b0, in_ch.byte_present}] <= '{op: OP_END, data: 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (take) r_wp <= r_wp + need;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (take ? {1'b0, need} : 3'd0) - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> design/md5_back.sv
`default_nettype none
// Block buffer, padding sequencer, one-round-per-cycle compression and digest output
module md5_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  md5_pkg::t_cmd     i_cmd,
    input  wire               i_cmd_valid,
    output logic              o_cmd_pop,
    md5_out_if.source         out_ch
);
    import md5_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_buf [16];
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_rnd, n_rnd;
    logic        r_final, n_final;
    logic [3:0]  r_oidx, n_oidx;
    logic        r_pad_extra, n_pad_extra;

    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        start_round, last_round;

    logic [1:0]  stage;
    logic [3:0]  g;
    logic [31:0] f, w, sum, rot;
    logic [4:0]  s;
    logic [31:0] digest_word;

    // round function, message word read from the buffer
    always_comb begin
        stage = r_rnd[5:4];
        unique case (stage)
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = r_rnd[3:0]; end
            2'd1: begin f = (r_b & r_d) | (r_c & ~r_d); g = 4'(5 * r_rnd + 1); end
            2'd2: begin f = r_b ^ r_c ^ r_d;            g = 4'(3 * r_rnd + 5); end
            default: begin f = r_c ^ (r_b | ~r_d);      g = 4'(7 * r_rnd); end
        endcase
        w   = r_buf[g];
        sum = r_a + f + round_const(r_rnd) + w;
        s   = rot_amount({stage, r_rnd[1:0]});
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    assign digest_word        = r_h[r_oidx[3:2]];
    assign out_ch.digest_byte = digest_word[{r_oidx[1:0], 3'b000} +: 8];
    assign out_ch.digest_last = r_oidx == 4'd15;
    assign out_ch.valid       = r_state == ST_EMIT;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_rnd       = r_rnd;
        n_final     = r_final;
        n_oidx      = r_oidx;
        o_cmd_pop   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_fill;
        wr_data     = i_cmd.data;
        start_round = 1'b0;
        last_round  = 1'b0;
        unique case (r_state)
            ST_GATHER: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    wr_en     = 1'b1;
                    n_fill    = r_fill + 6'd1;
                    if (i_cmd.op == OP_DATA) begin
                        n_bits = r_bits + 64'd8;
                        if (r_fill == 6'd63) begin
                            start_round = 1'b1;
                            n_final     = 1'b0;
                            n_state     = ST_ROUND;
                        end
                    end else begin
                        wr_data = 8'h80;
                        n_final = 1'b1;
                        n_state = (r_fill == 6'd63) ? ST_ROUND : ST_PAD;
                        start_round = r_fill == 6'd63;
                        if (r_fill == 6'd55) n_state = ST_LEN;
                    end
                end
            end
            ST_PAD: begin
                wr_en   = 1'b1;
                wr_data = 8'h00;
                n_fill  = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    start_round = 1'b1;
                    n_state     = ST_ROUND;
                end else if (r_fill == 6'd55 && r_final) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                wr_en   = 1'b1;
                wr_data = r_bits[{r_fill[2:0], 3'b000} +: 8];
                n_fill  = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    start_round = 1'b1;
                    n_state     = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    last_round = 1'b1;
                    n_oidx     = '0;
                    if (r_final && r_fill == 6'd0 && !r_pad_extra) n_state = ST_EMIT;
                    else if (r_pad_extra) n_state = ST_PAD;
                    else n_state = ST_GATHER;
                end
            end
            ST_EMIT: begin
                if (out_ch.ready) begin
                    n_oidx = r_oidx + 4'd1;
                    if (r_oidx == 4'd15) begin
                        n_state = ST_GATHER;
                        n_bits  = '0;
                        n_final = 1'b0;
                    end
                end
            end
            default: n_state = ST_GATHER;
        endcase
    end

    // an end mark past position 55 needs a second block of padding
    always_comb begin
        n_pad_extra = r_pad_extra;
        if (r_state == ST_GATHER && i_cmd_valid && i_cmd.op == OP_END)
            n_pad_extra = r_fill > 6'd55;
        else if (last_round)
            n_pad_extra = 1'b0;
    end

    // buffer write port, bytes packed little-endian into 16 words
    always_ff @(posedge i_clk) begin
        if (wr_en) r_buf[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end

    // working and chaining registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == ST_EMIT && out_ch.ready && r_oidx == 4'd15)) begin
            r_h[0] <= InitA;
            r_h[1] <= InitB;
            r_h[2] <= InitC;
            r_h[3] <= InitD;
        end else if (last_round) begin
            r_h[0] <= r_h[0] + r_d;
            r_h[1] <= r_h[1] + r_b + rot;
            r_h[2] <= r_h[2] + r_b;
            r_h[3] <= r_h[3] + r_c;
        end
        if (start_round) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else if (r_state == ST_ROUND) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_GATHER;
            r_fill      <= '0;
            r_bits      <= '0;
            r_rnd       <= '0;
            r_final     <= 1'b0;
            r_oidx      <= '0;
            r_pad_extra <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bits      <= n_bits;
            r_rnd       <= n_rnd;
            r_final     <= n_final;
            r_oidx      <= n_oidx;
            r_pad_extra <= n_pad_extra;
        end
    end
endmodule
`default_nettype wire

>>> design/md5_byte_stream_hasher.sv
`default_nettype none
// MD5 hasher for a byte stream. Each input transfer carries at most one message
// byte and an optional end mark. Bytes are taken at one per cycle into a small
// queue while it has room and gathered into a 64-byte block; every full block
// then takes 64 rounds in the single-round compression engine, during which
// input stalls once the queue fills. An end mark costs the padding and length
// writes up to the end of the block, then 64 rounds; when fewer than nine bytes
// are free, a second block of padding and 64 rounds follows. Then come 16
// digest transfers, word A first, least significant byte first, the last
// flagged. The block then resets for the next message.
module md5_byte_stream_hasher (
    input  wire        i_clk,
    input  wire        i_rst_n,
    md5_in_if.sink     in_ch,
    md5_out_if.source  out_ch
);
    import md5_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_pop;

    md5_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .o_cmd      (cmd),
        .o_cmd_valid(cmd_valid),
        .i_cmd_pop  (cmd_pop)
    );

    md5_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cmd_valid(cmd_valid),
        .o_cmd_pop  (cmd_pop),
        .out_ch     (out_ch)
    );
endmodule
`default_nettype wire
